### rtl/core/cle_pkg.sv
`default_nettype none
package cle_pkg;

	// default line store size
	localparam int LINE_CHARS_DEF = 64;

	// input operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_READ = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_LINE = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	// special characters
	localparam logic [7:0] CH_DEL = 8'h7f;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_LF  = 8'h0a;

	// controller states
	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic take_byte;
		logic take_read;
		logic issue;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic read_go;
		logic read_last;
	} sts_t;

endpackage
`default_nettype wire

### rtl/core/cle_ctrl.sv
`default_nettype none
module cle_ctrl
	import cle_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic opcode,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      busy
);

	state_t state_q;
	state_t state_d;
	logic   take;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take && opcode == OP_READ && sts.read_go) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (sts.read_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy          = 1'b0;
		take          = 1'b0;
		cmd.take_byte = 1'b0;
		cmd.take_read = 1'b0;
		cmd.issue     = 1'b0;
		case (state_q)
			S_IDLE: begin
				take          = start;
				cmd.take_byte = start && opcode == OP_BYTE;
				cmd.take_read = start && opcode == OP_READ;
			end
			S_READ: begin
				busy      = 1'b1;
				cmd.issue = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/cle_dp.sv
`default_nettype none
module cle_dp
	import cle_pkg::*;
#(
	parameter int LINE_CHARS = LINE_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [11:0] req_len,
	output logic             strobe,
	output logic [1:0]       status,
	output logic [7:0]       data,
	output logic             data_valid,
	output logic             last,
	output logic             line_ready,
	output logic [6:0]       fill_level
);

	localparam int IW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
	localparam int FW = $clog2(LINE_CHARS + 1);
	localparam logic [IW:0]   LC       = (IW + 1)'(LINE_CHARS);
	localparam logic [FW-1:0] FULL_CNT = FW'(LINE_CHARS);
	localparam logic [FW-1:0] LAST_IDX = FW'(LINE_CHARS - 1);

	// circular index add, result kept below the store size
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW:0] b);
		logic [IW:0] sum;
		sum = {1'b0, a} + b;
		if (sum >= LC) begin
			sum = sum - LC;
		end
		return sum[IW-1:0];
	endfunction

	logic [7:0]    mem [LINE_CHARS];
	logic [7:0]    rdata_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] rptr_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] remain_q;
	logic          complete_q;
	logic          strobe_q;
	logic [1:0]    status_q;
	logic          dv_q;
	logic          last_q;

	logic          full;
	logic          is_del;
	logic          is_nl;
	logic [FW-1:0] wr_off;
	logic [IW-1:0] wr_addr;
	logic          wr_en;
	logic [FW-1:0] n_take;

	// byte decode and write position
	always_comb begin
		full    = fill_q == FULL_CNT;
		is_del  = rx_byte == CH_DEL;
		is_nl   = rx_byte == CH_CR || rx_byte == CH_LF;
		wr_off  = full ? LAST_IDX : fill_q;
		wr_addr = wrap_add(head_q, (IW + 1)'(wr_off));
		wr_en   = cmd.take_byte && !complete_q && (is_nl || (!is_del && !full));
	end

	// read length and status to the controller
	always_comb begin
		n_take        = (req_len < 12'(fill_q)) ? req_len[FW-1:0] : fill_q;
		sts.read_go   = complete_q && n_take != '0;
		sts.read_last = remain_q == FW'(1);
	end

	// line store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= is_nl ? CH_LF : rx_byte;
		end
		if (cmd.issue) begin
			rdata_q <= mem[rptr_q];
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			rptr_q     <= '0;
			fill_q     <= '0;
			remain_q   <= '0;
			complete_q <= 1'b0;
		end else if (cmd.take_byte) begin
			if (!complete_q) begin
				if (is_del) begin
					if (fill_q != '0) begin
						fill_q <= fill_q - FW'(1);
					end
				end else if (is_nl) begin
					fill_q     <= full ? fill_q : fill_q + FW'(1);
					complete_q <= 1'b1;
				end else if (!full) begin
					fill_q <= fill_q + FW'(1);
				end
			end
		end else if (cmd.take_read) begin
			if (sts.read_go) begin
				rptr_q   <= head_q;
				remain_q <= n_take;
				head_q   <= wrap_add(head_q, (IW + 1)'(n_take));
				fill_q   <= fill_q - n_take;
				if (fill_q == n_take) begin
					complete_q <= 1'b0;
				end
			end
		end else if (cmd.issue) begin
			rptr_q   <= (rptr_q == LAST_IDX[IW-1:0]) ? '0 : rptr_q + IW'(1);
			remain_q <= remain_q - FW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			status_q <= ST_OK;
			dv_q     <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			if (cmd.take_byte) begin
				strobe_q <= 1'b1;
				status_q <= complete_q ? ST_REFUSED : ST_OK;
				dv_q     <= 1'b0;
				last_q   <= 1'b1;
			end else if (cmd.take_read && !sts.read_go) begin
				strobe_q <= 1'b1;
				status_q <= complete_q ? ST_OK : ST_NO_LINE;
				dv_q     <= 1'b0;
				last_q   <= 1'b1;
			end else if (cmd.issue) begin
				strobe_q <= 1'b1;
				status_q <= ST_OK;
				dv_q     <= 1'b1;
				last_q   <= sts.read_last;
			end else begin
				strobe_q <= 1'b0;
			end
		end
	end

	// result ports
	always_comb begin
		strobe     = strobe_q;
		status     = status_q;
		data       = dv_q ? rdata_q : 8'h00;
		data_valid = dv_q;
		last       = last_q;
		line_ready = complete_q;
		fill_level = 7'(fill_q);
	end

	// fill never exceeds the store
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond line store size");

	// a pending line is never empty
	a_line_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		complete_q |-> fill_q != '0)
		else $error("line pending with empty store");

	// every issued read has bytes left to deliver
	a_issue_remain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> remain_q != '0)
		else $error("read issued with nothing remaining");

	// an issued read delivers a byte in the next cycle
	a_issue_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> strobe_q && dv_q)
		else $error("issued read produced no data transfer");

endmodule
`default_nettype wire

### rtl/core/canonical_line_editor.sv
`default_nettype none
// Canonical-mode line editor.
// Command channel: an item is taken on a rising edge with start high and busy
// low. opcode 0 delivers a received byte in rx_byte; opcode 1 asks to read up
// to req_len bytes of a completed line.
// Result channel: each result is shown for one cycle with strobe high; the
// receiver cannot stall it, so every result must be taken when shown.
// A received byte gives one result in the cycle after it is taken, and busy
// stays low, so bytes may arrive back to back at one per cycle.
// A read with no pending line, or one that asks for zero bytes, also gives a
// single result in the next cycle. A read that delivers n bytes holds busy
// while the line store is read one byte per cycle through its single read
// port; each byte is registered together with its strobe, the final one
// marked by last. The next item may be taken in the cycle in which the final
// byte is shown.
// line_ready and fill_level always show the state after the shown item.
// Reset clears the fill count, the pending-line flag and the result strobe;
// the store contents are not cleared and need no clearing pass.
module canonical_line_editor
	import cle_pkg::*;
#(
	parameter int LINE_CHARS = LINE_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        opcode,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [11:0] req_len,
	output logic             strobe,
	output logic [1:0]       status,
	output logic [7:0]       data,
	output logic             data_valid,
	output logic             last,
	output logic             line_ready,
	output logic [6:0]       fill_level
);

	cmd_t cmd;
	sts_t sts;

	// sequencing
	cle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// line store and results
	cle_dp #(
		.LINE_CHARS (LINE_CHARS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.rx_byte    (rx_byte),
		.req_len    (req_len),
		.strobe     (strobe),
		.status     (status),
		.data       (data),
		.data_valid (data_valid),
		.last       (last),
		.line_ready (line_ready),
		.fill_level (fill_level)
	);

endmodule
`default_nettype wire

### bench/tb_canonical_line_editor.sv
module tb_canonical_line_editor
	import cle_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = LINE_CHARS_DEF;
	localparam int N_ITEMS    = 460;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_WAIT  = 8;

	// one command transfer
	typedef struct {
		logic        opcode;
		logic [7:0]  rx_byte;
		logic [11:0] req_len;
		bit          sync;
	} line_cmd_t;

	// one result transfer
	typedef struct {
		logic [1:0] status;
		logic [7:0] data;
		logic       data_valid;
		logic       last;
		logic       line_ready;
		logic [6:0] fill_level;
	} line_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        opcode;
	logic [7:0]  rx_byte;
	logic [11:0] req_len;
	logic        strobe;
	logic [1:0]  status;
	logic [7:0]  data;
	logic        data_valid;
	logic        last;
	logic        line_ready;
	logic [6:0]  fill_level;

	line_cmd_t    cmd_queue[$];
	line_result_t due_results[$];
	line_cmd_t    cur_cmd;

	// predicted editor state
	logic [7:0] held[DEPTH];
	int         held_n;
	logic       line_pending;

	logic took;
	int   sent_cnt;
	int   n_total;
	int   gap_left;
	int   calm_left;
	int   idle_cycles;
	int   fail_cnt;
	int   n_bytes, n_reads, n_results, n_delivered;
	int   n_refused, n_no_line, n_full;

	canonical_line_editor #(
		.LINE_CHARS(DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.rx_byte   (rx_byte),
		.req_len   (req_len),
		.strobe    (strobe),
		.status    (status),
		.data      (data),
		.data_valid(data_valid),
		.last      (last),
		.line_ready(line_ready),
		.fill_level(fill_level)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic add_cmd(input logic op, input logic [7:0] b, input logic [11:0] c,
			input bit sync);
		line_cmd_t it;
		it.opcode  = op;
		it.rx_byte = b;
		it.req_len = c;
		it.sync    = sync;
		cmd_queue.push_back(it);
	endtask

	// random byte that is neither delete nor a line end
	function automatic logic [7:0] plain_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(0, 255));
		if (ch == CH_DEL || ch == CH_CR || ch == CH_LF)
			ch = ch ^ 8'h20;
		return ch;
	endfunction

	// queue one expected result, carrying the after-step state
	task automatic log_result(input logic [1:0] st, input logic [7:0] d, input logic dv,
			input logic lst);
		line_result_t r;
		r.status     = st;
		r.data       = d;
		r.data_valid = dv;
		r.last       = lst;
		r.line_ready = line_pending;
		r.fill_level = 7'(held_n);
		due_results.push_back(r);
		n_results++;
	endtask

	// line editor prediction for one accepted command
	task automatic edit_line(input line_cmd_t it);
		int         take;
		logic [7:0] taken[DEPTH];
		if (it.opcode == OP_BYTE) begin
			n_bytes++;
			if (line_pending) begin
				n_refused++;
				log_result(ST_REFUSED, 8'h00, 1'b0, 1'b1);
			end else begin
				if (it.rx_byte == CH_DEL) begin
					if (held_n > 0)
						held_n--;
				end else if (it.rx_byte == CH_CR || it.rx_byte == CH_LF) begin
					// a newline on a full store takes the last slot
					if (held_n >= DEPTH) begin
						held_n = DEPTH - 1;
						n_full++;
					end
					held[held_n] = CH_LF;
					held_n++;
					line_pending = 1'b1;
				end else if (held_n < DEPTH) begin
					held[held_n] = it.rx_byte;
					held_n++;
				end else begin
					n_full++;
				end
				log_result(ST_OK, 8'h00, 1'b0, 1'b1);
			end
		end else begin
			n_reads++;
			if (!line_pending) begin
				n_no_line++;
				log_result(ST_NO_LINE, 8'h00, 1'b0, 1'b1);
			end else begin
				take = (int'(it.req_len) < held_n) ? int'(it.req_len) : held_n;
				if (take == 0) begin
					log_result(ST_OK, 8'h00, 1'b0, 1'b1);
				end else begin
					for (int k = 0; k < take; k++)
						taken[k] = held[k];
					// remainder moves to the front
					for (int k = 0; k < held_n - take; k++)
						held[k] = held[k + take];
					held_n -= take;
					if (held_n == 0)
						line_pending = 1'b0;
					for (int k = 0; k < take; k++)
						log_result(ST_OK, taken[k], 1'b1, (k == take - 1));
					n_delivered += take;
				end
			end
		end
	endtask

	task automatic cmp(input string name, input logic [11:0] exp_v, input logic [11:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	// driver: commands change on the falling edge
	always @(negedge clk) begin : driver
		int r;
		if (took) begin
			edit_line(cur_cmd);
			sent_cnt++;
			if (calm_left > 0) begin
				calm_left--;
				gap_left = 0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3)
					calm_left = $urandom_range(20, 60);
				gap_left = (r < 50) ? 0 : (r < 88) ? $urandom_range(1, 3) :
					$urandom_range(8, 40);
			end
		end
		if (start && !took) begin
			// hold the command until its transfer
		end else if (arst_n && gap_left == 0 && cmd_queue.size() != 0 &&
				!(cmd_queue[0].sync && due_results.size() != 0)) begin
			cur_cmd = cmd_queue.pop_front();
			opcode  <= cur_cmd.opcode;
			rx_byte <= cur_cmd.rx_byte;
			req_len <= cur_cmd.req_len;
			start   <= 1'b1;
		end else begin
			if (gap_left > 0)
				gap_left--;
			start   <= 1'b0;
			opcode  <= 1'($urandom_range(0, 1));
			rx_byte <= 8'($urandom_range(0, 255));
			req_len <= 12'($urandom_range(0, 4095));
		end
	end

	// monitor: transfers sampled on the rising edge
	always @(posedge clk) begin : monitor
		line_result_t e;
		took <= arst_n && start && !busy;
		if (strobe) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: status %0h data %0h", status, data);
				fail_cnt++;
			end else begin
				e = due_results.pop_front();
				cmp("status", 12'(e.status), 12'(status));
				cmp("data", 12'(e.data), 12'(data));
				cmp("data_valid", 12'(e.data_valid), 12'(data_valid));
				cmp("last", 12'(e.last), 12'(last));
				cmp("line_ready", 12'(e.line_ready), 12'(line_ready));
				cmp("fill_level", 12'(e.fill_level), 12'(fill_level));
			end
		end
		// watchdog on cycles with no transfer on either side
		if ((arst_n && start && !busy) || strobe)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin : stimulus
		int         r, len, nreads, seq;
		logic [11:0] cnt;

		arst_n       = 1'b0;
		start        = 1'b0;
		opcode       = OP_BYTE;
		rx_byte      = 8'h00;
		req_len      = 12'h000;
		took         = 1'b0;
		held_n       = 0;
		line_pending = 1'b0;
		sent_cnt     = 0;
		gap_left     = 0;
		calm_left    = 0;
		idle_cycles  = 0;
		fail_cnt     = 0;
		n_bytes = 0; n_reads = 0; n_results = 0; n_delivered = 0;
		n_refused = 0; n_no_line = 0; n_full = 0;

		// directed: empty-store cases, editing, refusal, partial and zero reads
		add_cmd(OP_READ, 8'hff, 12'hfff, 0);
		add_cmd(OP_BYTE, CH_DEL, 12'hfff, 0);
		add_cmd(OP_BYTE, 8'h00, 12'h000, 0);
		add_cmd(OP_BYTE, 8'hff, 12'hfff, 0);
		add_cmd(OP_BYTE, 8'h61, 12'h000, 0);
		add_cmd(OP_BYTE, CH_DEL, 12'h000, 0);
		add_cmd(OP_BYTE, CH_CR, 12'h000, 0);
		add_cmd(OP_BYTE, 8'h41, 12'h000, 0);
		add_cmd(OP_BYTE, CH_LF, 12'h000, 0);
		add_cmd(OP_BYTE, CH_DEL, 12'h000, 0);
		add_cmd(OP_READ, 8'h00, 12'd0, 0);
		add_cmd(OP_READ, 8'h00, 12'd1, 0);
		add_cmd(OP_READ, 8'hff, 12'hfff, 0);
		add_cmd(OP_READ, 8'h00, 12'd0, 0);
		add_cmd(OP_BYTE, CH_LF, 12'hfff, 0);
		add_cmd(OP_READ, 8'h00, 12'h800, 0);
		add_cmd(OP_BYTE, 8'h55, 12'h000, 0);
		add_cmd(OP_BYTE, 8'haa, 12'h000, 0);
		add_cmd(OP_BYTE, CH_CR, 12'h000, 0);
		add_cmd(OP_READ, 8'h00, 12'd2, 0);
		add_cmd(OP_READ, 8'h00, 12'h7ff, 0);
		add_cmd(OP_READ, 8'h00, 12'd1, 0);

		// random lines, first one overruns the store
		seq = 0;
		while (cmd_queue.size() < N_ITEMS) begin
			r = (seq == 0) ? 0 : $urandom_range(0, 99);
			if (r < 6) begin
				// overrun: extra bytes dropped, newline takes the last slot
				len = (seq == 0) ? 66 : $urandom_range(64, 68);
				for (int k = 0; k < len; k++)
					add_cmd(OP_BYTE, plain_char(), 12'($urandom_range(0, 4095)),
						(k == 0) && (seq == 0 || $urandom_range(0, 9) == 0));
				add_cmd(OP_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF, 12'h000, 0);
			end else if (r < 16) begin
				// noise: anything at all
				len = $urandom_range(3, 12);
				for (int k = 0; k < len; k++)
					add_cmd(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						$urandom_range(0, 1) ? 12'($urandom_range(0, 15)) :
						12'($urandom_range(0, 4095)), 0);
			end else begin
				// ordinary line with some deletes
				len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10) :
					$urandom_range(11, 63);
				if ($urandom_range(0, 9) == 0)
					add_cmd(OP_READ, 8'($urandom_range(0, 255)),
						12'($urandom_range(0, 4095)), 0);
				for (int k = 0; k < len; k++)
					add_cmd(OP_BYTE, ($urandom_range(0, 9) == 0) ? CH_DEL : plain_char(),
						12'($urandom_range(0, 4095)),
						(k == 0) && ($urandom_range(0, 19) == 0));
				add_cmd(OP_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF,
					12'($urandom_range(0, 4095)), 0);
			end
			// bytes that arrive while the line waits
			if ($urandom_range(0, 9) < 3) begin
				len = $urandom_range(1, 2);
				for (int k = 0; k < len; k++)
					add_cmd(OP_BYTE, 8'($urandom_range(0, 255)),
						12'($urandom_range(0, 4095)), 0);
			end
			// reads, the final one large enough to drain
			nreads = $urandom_range(1, 3);
			for (int k = 0; k < nreads; k++) begin
				r = $urandom_range(0, 99);
				if (k == nreads - 1)
					cnt = (r < 50) ? 12'hfff : 12'($urandom_range(64, 4095));
				else if (r < 5)
					cnt = 12'd0;
				else if (r < 55)
					cnt = 12'($urandom_range(1, 8));
				else
					cnt = 12'($urandom_range(0, 4095));
				add_cmd(OP_READ, 8'($urandom_range(0, 255)), cnt, 0);
			end
			seq++;
		end
		n_total = cmd_queue.size();

		// reset
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain
		while (sent_cnt != n_total || due_results.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (TAIL_WAIT) @(posedge clk);
		#1;
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			fail_cnt++;
		end

		$display("run covered %0d byte and %0d read transfers over %0d lines, %0d results",
			n_bytes, n_reads, seq, n_results);
		$display("%0d bytes delivered, %0d refused, %0d reads without a line, %0d full-store",
			n_delivered, n_refused, n_no_line, n_full);
		if (fail_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/cle_pkg.sv
rtl/core/cle_ctrl.sv
rtl/core/cle_dp.sv
rtl/core/canonical_line_editor.sv
bench/tb_canonical_line_editor.sv
